@@ hdl/mfd_pkg.sv @@
// Shared types and constants of the motor feedback frame decoder.
// Used by the serial multiplier, the top level and the checker; depends on nothing.
package mfd_pkg;

   localparam int FRAME_W    = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int MCAND_W  = 34;
   localparam int MPLIER_W = 32;
   localparam int ACC_W    = MCAND_W + 1;
   localparam int CNT_W    = $clog2(MPLIER_W);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MPLIER_W - 1);

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic [7:0] CODE_READ_STATE   = 8'h9C;
   localparam logic [7:0] CODE_TORQUE_REPLY = 8'hA1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_WEIGHT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_WEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE_PER_CNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIAN_PER_CNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_TIMEOUT    = 3'd4;

   localparam logic [16:0] WEIGHT_ONE       = 17'h10000;
   localparam logic [24:0] DEG_PER_CNT_INIT = 25'd23592960;
   localparam logic [24:0] RAD_PER_CNT_INIT = 25'd411775;
   localparam logic [7:0]  TIMEOUT_INIT     = 8'd20;
   localparam logic [26:0] DEG_TO_RAD_Q32   = 27'd74961321;

   typedef struct packed {
      logic               kind;
      logic [FRAME_W-1:0] frame_data;
   } req_type;

   typedef struct packed {
      logic [15:0]        encoder_count;
      logic [15:0]        previous_encoder_count;
      logic [24:0]        angle_degrees;
      logic [24:0]        angle_radians;
      logic signed [31:0] speed_deg_rate;
      logic signed [31:0] speed_rad_rate;
      logic signed [31:0] current_level;
      logic [7:0]         temperature;
      logic               link_lost;
      logic               frame_used;
   } rsp_type;

endpackage

@@ hdl/mfd_ser_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, product in acc and low shift reg.
// Depends on mfd_pkg for its widths.
module mfd_ser_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [mfd_pkg::MCAND_W-1:0]  mcand,
   input  logic signed [mfd_pkg::MPLIER_W-1:0] mplier,
   output logic                              done,
   output logic signed [mfd_pkg::ACC_W-1:0]    prod_hi,
   output logic [mfd_pkg::MPLIER_W-1:0]        prod_lo
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mfd_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [mfd_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [mfd_pkg::MPLIER_W-1:0]      lo_ff, lo_in;
   logic signed [mfd_pkg::MCAND_W-1:0] mc_ff, mc_in;
   logic signed [mfd_pkg::ACC_W:0]    mc_ext, addend, sum;
   logic                              last;

   // The top multiplier bit carries negative weight, so the last step subtracts.
   always_comb begin
      last   = (cnt_ff == mfd_pkg::MUL_LAST);
      mc_ext = {{2{mc_ff[mfd_pkg::MCAND_W-1]}}, mc_ff};
      if (!lo_ff[0]) begin
         addend = '0;
      end else if (last) begin
         addend = -mc_ext;
      end else begin
         addend = mc_ext;
      end
      sum = {acc_ff[mfd_pkg::ACC_W-1], acc_ff} + addend;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      mc_in   = mc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         lo_in   = mplier;
         mc_in   = mcand;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         acc_in = sum[mfd_pkg::ACC_W:1];
         lo_in  = {sum[0], lo_ff[mfd_pkg::MPLIER_W-1:1]};
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
      mc_ff  <= mc_in;
   end

   assign done    = done_ff;
   assign prod_hi = acc_ff;
   assign prod_lo = lo_ff;

endmodule

@@ hdl/motor_feedback_frame_decoder.sv @@
// Requests are accepted one at a time, and each goes through three multiply phases.
// Each phase loads two bit-serial multipliers, shifts through the multiplier bits and hands over.
// A waiting response does not block acceptance of the next request.
// Reset is synchronous and active high; it clears the held state and restores the registers.
// Depends on mfd_pkg and mfd_ser_mul.
module motor_feedback_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mfd_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mfd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mfd_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [1:0] PH_SPEED_DEG = 2'd0;
   localparam logic [1:0] PH_RPS_CUR   = 2'd1;
   localparam logic [1:0] PH_RAD       = 2'd2;

   logic [16:0] speed_weight_ff, current_weight_ff;
   logic [24:0] degree_per_count_ff, radian_per_count_ff;
   logic [7:0]  lost_timeout_ff;

   logic [1:0]  state_ff, phase_ff;
   logic        start_ff;
   logic        rsp_valid_ff;
   mfd_pkg::rsp_type rsp_data_ff;

   logic [15:0]        encoder_now_ff, encoder_before_ff;
   logic signed [31:0] speed_avg_ff, current_avg_ff;
   logic [7:0]         temperature_ff, silence_ff;
   logic               lost_ff, used_ff;
   logic [15:0]        speed_raw_ff, current_raw_ff;

   logic [24:0]        angle_deg_ff, angle_rad_ff;
   logic signed [31:0] speed_rad_ff;

   logic        req_accept, frame_known;
   logic [7:0]  silence_in;
   logic [16:0] speed_w_sat, current_w_sat;
   logic signed [mfd_pkg::MCAND_W-1:0]  a0, a1, speed_diff, current_diff;
   logic signed [mfd_pkg::MPLIER_W-1:0] b0, b1;
   logic        u0_done, u1_done;
   logic signed [mfd_pkg::ACC_W-1:0] u0_hi, u1_hi;
   logic [mfd_pkg::MPLIER_W-1:0]     u0_lo, u1_lo;
   logic [31:0] r16_0, r16_1, r32_0;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      frame_known = (req_data.frame_data[7:0] == mfd_pkg::CODE_READ_STATE) ||
                    (req_data.frame_data[7:0] == mfd_pkg::CODE_TORQUE_REPLY);
      silence_in  = (silence_ff == 8'hFF) ? silence_ff : silence_ff + 8'd1;
      speed_w_sat   = speed_weight_ff[16] ? mfd_pkg::WEIGHT_ONE : speed_weight_ff;
      current_w_sat = current_weight_ff[16] ? mfd_pkg::WEIGHT_ONE : current_weight_ff;
      speed_diff   = {{2{speed_raw_ff[15]}}, speed_raw_ff, 16'b0} -
                     {{2{speed_avg_ff[31]}}, speed_avg_ff};
      current_diff = {{2{current_raw_ff[15]}}, current_raw_ff, 16'b0} -
                     {{2{current_avg_ff[31]}}, current_avg_ff};
   end

   always_comb begin
      case (phase_ff)
         PH_SPEED_DEG: begin
            a0 = speed_diff;
            b0 = {15'b0, speed_w_sat};
            a1 = {9'b0, degree_per_count_ff};
            b1 = {16'b0, encoder_now_ff};
         end
         PH_RPS_CUR: begin
            a0 = {7'b0, mfd_pkg::DEG_TO_RAD_Q32};
            b0 = speed_avg_ff;
            a1 = current_diff;
            b1 = {15'b0, current_w_sat};
         end
         default: begin
            a0 = '0;
            b0 = '0;
            a1 = {9'b0, radian_per_count_ff};
            b1 = {16'b0, encoder_now_ff};
         end
      endcase
   end

   mfd_ser_mul u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .mcand   (a0),
      .mplier  (b0),
      .done    (u0_done),
      .prod_hi (u0_hi),
      .prod_lo (u0_lo)
   );

   mfd_ser_mul u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .mcand   (a1),
      .mplier  (b1),
      .done    (u1_done),
      .prod_hi (u1_hi),
      .prod_lo (u1_lo)
   );

   // Products shifted down by 16 or 32 bits, rounded half up.
   always_comb begin
      r16_0 = {u0_hi[15:0], u0_lo[31:16]} + {31'b0, u0_lo[15]};
      r16_1 = {u1_hi[15:0], u1_lo[31:16]} + {31'b0, u1_lo[15]};
      r32_0 = u0_hi[31:0] + {31'b0, u0_lo[31]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_weight_ff     <= mfd_pkg::WEIGHT_ONE;
         current_weight_ff   <= mfd_pkg::WEIGHT_ONE;
         degree_per_count_ff <= mfd_pkg::DEG_PER_CNT_INIT;
         radian_per_count_ff <= mfd_pkg::RAD_PER_CNT_INIT;
         lost_timeout_ff     <= mfd_pkg::TIMEOUT_INIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mfd_pkg::CSR_SPEED_WEIGHT:   speed_weight_ff     <= csr_data[16:0];
            mfd_pkg::CSR_CURRENT_WEIGHT: current_weight_ff   <= csr_data[16:0];
            mfd_pkg::CSR_DEGREE_PER_CNT: degree_per_count_ff <= csr_data[24:0];
            mfd_pkg::CSR_RADIAN_PER_CNT: radian_per_count_ff <= csr_data[24:0];
            mfd_pkg::CSR_LOST_TIMEOUT:   lost_timeout_ff     <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         phase_ff          <= PH_SPEED_DEG;
         start_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         encoder_now_ff    <= '0;
         encoder_before_ff <= '0;
         speed_avg_ff      <= '0;
         current_avg_ff    <= '0;
         temperature_ff    <= '0;
         silence_ff        <= '0;
         lost_ff           <= 1'b0;
         used_ff           <= 1'b0;
      end else begin
         start_ff <= req_accept ||
                     (state_ff == ST_MUL && u0_done && u1_done &&
                      (phase_ff == PH_SPEED_DEG || phase_ff == PH_RPS_CUR));
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_MUL;
                  phase_ff <= PH_SPEED_DEG;
                  if (req_data.kind == mfd_pkg::KIND_FRAME) begin
                     silence_ff <= '0;
                     lost_ff    <= 1'b0;
                     used_ff    <= frame_known;
                     if (frame_known) begin
                        encoder_before_ff <= encoder_now_ff;
                        encoder_now_ff    <= req_data.frame_data[63:48];
                        temperature_ff    <= req_data.frame_data[15:8];
                     end
                  end else begin
                     silence_ff <= silence_in;
                     used_ff    <= 1'b0;
                     if (silence_in >= lost_timeout_ff) begin
                        lost_ff <= 1'b1;
                     end
                  end
               end
            end
            ST_MUL: begin
               if (u0_done && u1_done) begin
                  case (phase_ff)
                     PH_SPEED_DEG: begin
                        if (used_ff) begin
                           speed_avg_ff <= speed_avg_ff + r16_0;
                        end
                        phase_ff <= PH_RPS_CUR;
                     end
                     PH_RPS_CUR: begin
                        if (used_ff) begin
                           current_avg_ff <= current_avg_ff + r16_1;
                        end
                        phase_ff <= PH_RAD;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         speed_raw_ff   <= req_data.frame_data[47:32];
         current_raw_ff <= req_data.frame_data[31:16];
      end
      if (state_ff == ST_MUL && u0_done && u1_done) begin
         case (phase_ff)
            PH_SPEED_DEG: angle_deg_ff <= r16_1[24:0];
            PH_RPS_CUR:   speed_rad_ff <= r32_0;
            default:      angle_rad_ff <= r16_1[24:0];
         endcase
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff.encoder_count          <= encoder_now_ff;
         rsp_data_ff.previous_encoder_count <= encoder_before_ff;
         rsp_data_ff.angle_degrees          <= angle_deg_ff;
         rsp_data_ff.angle_radians          <= angle_rad_ff;
         rsp_data_ff.speed_deg_rate         <= speed_avg_ff;
         rsp_data_ff.speed_rad_rate         <= speed_rad_ff;
         rsp_data_ff.current_level          <= current_avg_ff;
         rsp_data_ff.temperature            <= temperature_ff;
         rsp_data_ff.link_lost              <= lost_ff;
         rsp_data_ff.frame_used             <= used_ff;
      end
   end

endmodule

@@ hdl/mfd_checker.sv @@
// Port-level checks of the motor feedback frame decoder, bound to the top level.
// Depends on mfd_pkg and motor_feedback_frame_decoder.
module mfd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mfd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mfd_pkg::rsp_type rsp_data
);

   // A stalled response keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // The block takes one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.kind == mfd_pkg::KIND_TICK ||
                                 req_data.kind == mfd_pkg::KIND_FRAME) |=> !req_ready)
      else $error("request accepted while busy");

   // A used frame always clears the lost flag.
   a_used_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.frame_used && rsp_data.link_lost))
      else $error("used frame reported with link lost");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind motor_feedback_frame_decoder mfd_checker u_mfd_checker (.*);

@@ verif/motor_feedback_frame_decoder_test.sv @@
// Self-checking testbench for the motor feedback frame decoder: frames and ticks go in through
// a valid/ready channel, and each status response is compared with a model held in the bench.
// Depends on mfd_pkg and on the decoder RTL.
module motor_feedback_frame_decoder_test;
   import mfd_pkg::*;

   localparam int CSR_COUNT       = 5;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 150;
   localparam int IDLE_PERCENT    = 18;
   localparam int REPORT_LIMIT    = 10;
   localparam int MAX_BURST       = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logic [16:0]        speed_weight_q;
   logic [16:0]        current_weight_q;
   logic [24:0]        degree_per_count_q;
   logic [24:0]        radian_per_count_q;
   logic [7:0]         timeout_ticks_q;
   logic [15:0]        encoder_now_q;
   logic [15:0]        encoder_before_q;
   logic signed [31:0] speed_average_q;
   logic signed [31:0] current_average_q;
   logic [7:0]         temperature_q;
   logic [7:0]         silence_ticks_q;
   logic               link_lost_q;

   rsp_type expected_status[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      hold_off_asked = 0;
   int      hold_off_served;
   logic    steady_flow = 1'b0;

   motor_feedback_frame_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [24:0] scaled_angle(input logic [15:0] count,
                                                input logic [24:0] coef);
      logic [63:0] product;
      product = 64'(count) * 64'(coef) + 64'd32768;
      return product[40:16];
   endfunction

   function automatic logic signed [31:0] averaged(input logic signed [31:0] average,
                                                   input logic signed [15:0] sample,
                                                   input logic [16:0] weight);
      longint w;
      longint t;
      w = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
      t = (longint'(WEIGHT_ONE) - w) * longint'(average) + w * (longint'(sample) * 65536);
      t = (t + 32768) >>> 16;
      return t[31:0];
   endfunction

   function automatic logic signed [31:0] to_radians(input logic signed [31:0] dps);
      longint t;
      t = longint'(dps) * longint'(DEG_TO_RAD_Q32);
      t = (t + 64'sd2147483648) >>> 32;
      return t[31:0];
   endfunction

   function automatic void reset_predictor();
      speed_weight_q     = WEIGHT_ONE;
      current_weight_q   = WEIGHT_ONE;
      degree_per_count_q = DEG_PER_CNT_INIT;
      radian_per_count_q = RAD_PER_CNT_INIT;
      timeout_ticks_q    = TIMEOUT_INIT;
      encoder_now_q      = '0;
      encoder_before_q   = '0;
      speed_average_q    = '0;
      current_average_q  = '0;
      temperature_q      = '0;
      silence_ticks_q    = '0;
      link_lost_q        = 1'b0;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_SPEED_WEIGHT:   speed_weight_q     = value[16:0];
         CSR_CURRENT_WEIGHT: current_weight_q   = value[16:0];
         CSR_DEGREE_PER_CNT: degree_per_count_q = value[24:0];
         CSR_RADIAN_PER_CNT: radian_per_count_q = value[24:0];
         CSR_LOST_TIMEOUT:   timeout_ticks_q    = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic rsp_type predict_status(input req_type item);
      rsp_type    status;
      logic       used;
      logic [7:0] code;
      used = 1'b0;
      code = item.frame_data[7:0];
      if (item.kind == KIND_FRAME) begin
         silence_ticks_q = '0;
         link_lost_q = 1'b0;
         if (code == CODE_READ_STATE || code == CODE_TORQUE_REPLY) begin
            used = 1'b1;
            encoder_before_q = encoder_now_q;
            encoder_now_q = item.frame_data[63:48];
            speed_average_q = averaged(speed_average_q, item.frame_data[47:32],
                                       speed_weight_q);
            current_average_q = averaged(current_average_q, item.frame_data[31:16],
                                         current_weight_q);
            temperature_q = item.frame_data[15:8];
         end
      end else begin
         if (silence_ticks_q != 8'hFF) begin
            silence_ticks_q = silence_ticks_q + 8'd1;
         end
         if (silence_ticks_q >= timeout_ticks_q) begin
            link_lost_q = 1'b1;
         end
      end
      status.encoder_count          = encoder_now_q;
      status.previous_encoder_count = encoder_before_q;
      status.angle_degrees          = scaled_angle(encoder_now_q, degree_per_count_q);
      status.angle_radians          = scaled_angle(encoder_now_q, radian_per_count_q);
      status.speed_deg_rate         = speed_average_q;
      status.speed_rad_rate         = to_radians(speed_average_q);
      status.current_level          = current_average_q;
      status.temperature            = temperature_q;
      status.link_lost              = link_lost_q;
      status.frame_used             = used;
      return status;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch in %s at cycle %0d: expected %h, got %h.",
                     field, cycle_count, want, got);
         end
      end
   endtask

   task automatic check_status(input rsp_type got);
      rsp_type want;
      if (expected_status.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("Response with no request outstanding at cycle %0d.", cycle_count);
         end
      end else begin
         want = expected_status.pop_front();
         compare_field("encoder_count", 32'(want.encoder_count), 32'(got.encoder_count));
         compare_field("previous_encoder_count", 32'(want.previous_encoder_count),
                       32'(got.previous_encoder_count));
         compare_field("angle_degrees", 32'(want.angle_degrees), 32'(got.angle_degrees));
         compare_field("angle_radians", 32'(want.angle_radians), 32'(got.angle_radians));
         compare_field("speed_deg_rate", want.speed_deg_rate, got.speed_deg_rate);
         compare_field("speed_rad_rate", want.speed_rad_rate, got.speed_rad_rate);
         compare_field("current_level", want.current_level, got.current_level);
         compare_field("temperature", 32'(want.temperature), 32'(got.temperature));
         compare_field("link_lost", 32'(want.link_lost), 32'(got.link_lost));
         compare_field("frame_used", 32'(want.frame_used), 32'(got.frame_used));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            expected_status.push_back(predict_status(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            check_status(rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      hold_off_served = 0;
      forever begin
         @(negedge clock);
         if (hold_off_served != hold_off_asked) begin
            hold_off_served = hold_off_asked;
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_ready = steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   function automatic req_type frame_request(input logic [7:0] code, input logic [15:0] count,
                                             input logic [15:0] speed,
                                             input logic [15:0] current,
                                             input logic [7:0] temp);
      req_type item;
      item.kind = KIND_FRAME;
      item.frame_data = {count, speed, current, temp, code};
      return item;
   endfunction

   function automatic req_type random_frame(input bit recognized);
      req_type item;
      item.kind = KIND_FRAME;
      item.frame_data = {$urandom, $urandom};
      if (recognized) begin
         item.frame_data[7:0] = $urandom_range(1) ? CODE_READ_STATE : CODE_TORQUE_REPLY;
      end
      return item;
   endfunction

   function automatic req_type tick_request();
      req_type item;
      item.kind = KIND_TICK;
      item.frame_data = {$urandom, $urandom};
      return item;
   endfunction

   task automatic send_request(input req_type item);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
      end
      req_data = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_request(tick_request());
   endtask

   task automatic wait_all_results();
      while (expected_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input int value,
                                 input int width);
      logic [31:0] keep;
      keep = (32'd1 << width) - 32'd1;
      csr_index = index;
      csr_data = ($urandom & ~keep) | (32'(value) & keep);
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input int speed_w, input int current_w, input int deg,
                             input int rad, input int timeout);
      wait_all_results();
      write_register(CSR_SPEED_WEIGHT, speed_w, 17);
      write_register(CSR_CURRENT_WEIGHT, current_w, 17);
      write_register(CSR_DEGREE_PER_CNT, deg, 25);
      write_register(CSR_RADIAN_PER_CNT, rad, 25);
      write_register(CSR_LOST_TIMEOUT, timeout, 8);
   endtask

   task automatic run_random_traffic(input int count);
      int sent;
      int pick;
      int burst;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            burst = $urandom_range(1, int'(timeout_ticks_q) + 4);
            if (burst > MAX_BURST) begin
               burst = MAX_BURST;
            end
            send_ticks(burst);
            sent += burst;
         end else begin
            if (pick < 25) begin
               send_request(tick_request());
            end else if (pick < 85) begin
               send_request(random_frame(1'b1));
            end else begin
               send_request(random_frame(1'b0));
            end
            sent++;
         end
      end
   endtask

   task automatic test_frame_decoding();
      send_request(frame_request(CODE_READ_STATE, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF));
      send_request(frame_request(CODE_TORQUE_REPLY, 16'h0000, 16'h8000, 16'h7FFF, 8'h00));
      send_request(frame_request(CODE_READ_STATE, 16'h8000, 16'hFFFF, 16'h0001, 8'h5A));
      send_request(frame_request(8'h00, 16'h1234, 16'h4321, 16'h1111, 8'h22));
      send_request(frame_request(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_request(frame_request(CODE_READ_STATE + 8'd1, 16'hABCD, 16'h0100, 16'hFF00, 8'h33));
   endtask

   task automatic test_link_timeout();
      set_config(int'(WEIGHT_ONE), int'(WEIGHT_ONE), int'(DEG_PER_CNT_INIT),
                 int'(RAD_PER_CNT_INIT), 2);
      send_ticks(3);
      send_request(random_frame(1'b0));
      send_ticks(3);
      send_request(random_frame(1'b1));
      set_config(int'(WEIGHT_ONE), int'(WEIGHT_ONE), int'(DEG_PER_CNT_INIT),
                 int'(RAD_PER_CNT_INIT), 0);
      send_ticks(1);
      send_request(random_frame(1'b1));
   endtask

   task automatic test_silence_saturation();
      set_config(int'(WEIGHT_ONE), int'(WEIGHT_ONE), int'(DEG_PER_CNT_INIT),
                 int'(RAD_PER_CNT_INIT), 255);
      send_ticks(300);
      send_request(random_frame(1'b1));
      send_ticks(3);
   endtask

   task automatic test_config_sweep();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_config(0, 0, 33554431, 33554431, 1);
            1: set_config(65536, 65536, 0, 0, 255);
            2: set_config(131071, 65537, int'(DEG_PER_CNT_INIT), int'(RAD_PER_CNT_INIT), 0);
            3: set_config(1, 65535, $urandom_range(33554431), $urandom_range(33554431), 3);
            4: set_config(32768, 16384, $urandom_range(33554431), $urandom_range(33554431),
                          $urandom_range(1, 40));
            default: set_config($urandom_range(131071), $urandom_range(131071),
                                $urandom_range(33554431), $urandom_range(33554431),
                                $urandom_range(1, 40));
         endcase
         if (phase == 0) begin
            for (int i = CSR_COUNT; i < 2 ** CSR_IDX_W; i++) begin
               write_register(CSR_IDX_W'(i), $urandom, 32);
            end
         end
         run_random_traffic(110);
      end
   endtask

   task automatic test_backpressure();
      set_config(40000, 20000, int'(DEG_PER_CNT_INIT), int'(RAD_PER_CNT_INIT), 5);
      hold_off_asked++;
      run_random_traffic(16);
      wait_all_results();
      run_random_traffic(10);
   endtask

   task automatic test_steady_stream();
      steady_flow = 1'b1;
      run_random_traffic(150);
      steady_flow = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset_predictor();
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_frame_decoding();
      test_link_timeout();
      test_silence_saturation();
      test_config_sweep();
      test_backpressure();
      test_steady_stream();
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
